>>> src/terq_pkg.sv
package terq_pkg;

    localparam int TABLE_DEPTH   = 64;
    localparam int EVENT_ID_BITS = 8;
    localparam int TIME_BITS     = 32;
    localparam int IDX_BITS      = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS      = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [1:0]                      kind;
        logic signed [TIME_BITS-1:0]     time_req;
        logic signed [TIME_BITS-1:0]     range_end;
        logic [EVENT_ID_BITS-1:0]        event_id;
    } t_in_item;

    typedef struct packed {
        logic                            found;
        logic [EVENT_ID_BITS-1:0]        event_out;
        logic                            status;
        logic                            last;
    } t_out_item;

    typedef struct packed {
        logic signed [TIME_BITS-1:0]     tm;
        logic [EVENT_ID_BITS-1:0]        ev;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

endpackage

>>> src/terq_ram.sv
module terq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/timed_event_range_query_core.sv
// Sorted event table with time range queries. Entries live in one single-port-read RAM kept
// in ascending time order; one signed 32-bit comparator does all the work. Clear empties the
// table. Add moves each stored entry with a later time up one slot, a read and a write per
// entry, then writes the new one; a full table answers with STATUS_FULL. Sample first picks
// the direction, then runs a binary search for the range start, then reads the
// matched entries one by one and closes out. A result still waiting in the output
// register holds the block at each further match and at the final result.
// The block takes no new item until the current one has issued its final result into
// the output register; that register lets a new item in while the result waits.
module timed_event_range_query_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  terq_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output terq_pkg::t_out_item o_out_item
);
    import terq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIR, S_ADD_RD, S_ADD_CMP, S_BS_RD, S_BS_CMP, S_SC_RD, S_SC_CMP, S_DONE
    } t_state;

    t_state                       r_state, n_state;
    logic signed [TIME_BITS-1:0]  r_t0, n_t0, r_t1, n_t1;
    logic [EVENT_ID_BITS-1:0]     r_ev, n_ev;
    logic [CNT_BITS-1:0]          r_count, n_count;
    logic [CNT_BITS-1:0]          r_idx, n_idx;
    logic [CNT_BITS-1:0]          r_lo, n_lo, r_hi, n_hi;
    logic                         r_rev, n_rev;
    logic                         r_pend_valid, n_pend_valid;
    logic [EVENT_ID_BITS-1:0]     r_pend_ev, n_pend_ev;
    logic                         r_status, n_status;
    logic                         r_out_valid, n_out_valid;
    t_out_item                    r_out, n_out;

    logic                         wr_en;
    logic [IDX_BITS-1:0]          wr_addr, rd_addr;
    t_entry                       wr_data, rd_entry;
    logic [ENTRY_BITS-1:0]        ram_rd_data;

    logic [CNT_BITS-1:0]          idx_m1;
    logic [CNT_BITS:0]            mid_sum;
    logic [CNT_BITS-1:0]          mid;
    logic signed [TIME_BITS-1:0]  cmp_x, cmp_y;
    logic                         cmp_lt;
    logic                         can_push, push;
    t_out_item                    push_item;

    terq_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign rd_entry = ram_rd_data;
    assign idx_m1   = r_idx - CNT_BITS'(1);
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = mid_sum[CNT_BITS:1];
    assign can_push = !r_out_valid || i_out_ready;

    // read address is a function of state and registers, so it holds while a state stalls
    always_comb begin
        case (r_state)
            S_BS_RD, S_BS_CMP: rd_addr = mid[IDX_BITS-1:0];
            S_SC_RD, S_SC_CMP: rd_addr = r_rev ? idx_m1[IDX_BITS-1:0] : r_idx[IDX_BITS-1:0];
            default:           rd_addr = idx_m1[IDX_BITS-1:0];
        endcase
    end

    // the shared comparator
    always_comb begin
        case (r_state)
            S_DIR: begin
                cmp_x = r_t1;
                cmp_y = r_t0;
            end
            S_BS_CMP: begin
                cmp_x = r_rev ? r_t0 : rd_entry.tm;
                cmp_y = r_rev ? rd_entry.tm : r_t0;
            end
            S_SC_CMP: begin
                cmp_x = r_rev ? r_t1 : rd_entry.tm;
                cmp_y = r_rev ? rd_entry.tm : r_t1;
            end
            default: begin
                cmp_x = r_t0;
                cmp_y = rd_entry.tm;
            end
        endcase
        cmp_lt = cmp_x < cmp_y;
    end

    always_comb begin
        n_state      = r_state;
        n_t0         = r_t0;
        n_t1         = r_t1;
        n_ev         = r_ev;
        n_count      = r_count;
        n_idx        = r_idx;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_rev        = r_rev;
        n_pend_valid = r_pend_valid;
        n_pend_ev    = r_pend_ev;
        n_status     = r_status;
        wr_en        = 1'b0;
        wr_addr      = r_idx[IDX_BITS-1:0];
        wr_data      = rd_entry;
        push         = 1'b0;
        push_item    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_t0         = i_in_item.time_req;
                    n_t1         = i_in_item.range_end;
                    n_ev         = i_in_item.event_id;
                    n_pend_valid = 1'b0;
                    n_status     = STATUS_OK;
                    case (i_in_item.kind)
                        KIND_CLEAR: begin
                            n_count = '0;
                            n_state = S_DONE;
                        end
                        KIND_ADD: begin
                            if (r_count == CNT_BITS'(TABLE_DEPTH)) begin
                                n_status = STATUS_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_ADD_RD;
                            end
                        end
                        KIND_SAMPLE: begin
                            n_lo    = '0;
                            n_hi    = r_count;
                            n_state = S_DIR;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_RD: begin
                if (r_idx == '0) begin
                    wr_en   = 1'b1;
                    wr_data = '{tm: r_t0, ev: r_ev};
                    n_count = r_count + CNT_BITS'(1);
                    n_state = S_DONE;
                end else begin
                    n_state = S_ADD_CMP;
                end
            end
            S_ADD_CMP: begin
                wr_en = 1'b1;
                if (cmp_lt) begin
                    // entry later than the new time moves up a slot
                    n_idx   = idx_m1;
                    n_state = S_ADD_RD;
                end else begin
                    wr_data = '{tm: r_t0, ev: r_ev};
                    n_count = r_count + CNT_BITS'(1);
                    n_state = S_DONE;
                end
            end
            S_DIR: begin
                n_rev   = cmp_lt;
                n_state = S_BS_RD;
            end
            S_BS_RD: begin
                if (r_lo == r_hi) begin
                    n_idx   = r_lo;
                    n_state = S_SC_RD;
                end else begin
                    n_state = S_BS_CMP;
                end
            end
            S_BS_CMP: begin
                // forward: first time >= start; reverse: first time > start
                if (r_rev ? cmp_lt : !cmp_lt) begin
                    n_hi = mid;
                end else begin
                    n_lo = mid + CNT_BITS'(1);
                end
                n_state = S_BS_RD;
            end
            S_SC_RD: begin
                if (r_rev ? (r_idx == '0) : (r_idx == r_count)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SC_CMP;
                end
            end
            S_SC_CMP: begin
                if (!cmp_lt) begin
                    n_state = S_DONE;
                end else if (!r_pend_valid || can_push) begin
                    // hold one match back so the final one can carry last
                    if (r_pend_valid) begin
                        push      = 1'b1;
                        push_item = '{found: 1'b1, event_out: r_pend_ev,
                                      status: STATUS_OK, last: 1'b0};
                    end
                    n_pend_valid = 1'b1;
                    n_pend_ev    = rd_entry.ev;
                    n_idx        = r_rev ? idx_m1 : r_idx + CNT_BITS'(1);
                    n_state      = S_SC_RD;
                end
            end
            S_DONE: begin
                if (can_push) begin
                    push         = 1'b1;
                    push_item    = '{found: r_pend_valid,
                                     event_out: r_pend_valid ? r_pend_ev : '0,
                                     status: r_status, last: 1'b1};
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (push) begin
            n_out_valid = 1'b1;
            n_out       = push_item;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t0      <= n_t0;
        r_t1      <= n_t1;
        r_ev      <= n_ev;
        r_idx     <= n_idx;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_rev     <= n_rev;
        r_pend_ev <= n_pend_ev;
        r_status  <= n_status;
        r_out     <= n_out;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BS_RD || r_state == S_BS_CMP) |-> (r_lo <= r_hi && r_hi <= r_count))
        else $error("binary search window out of order");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_item.kind != KIND_UNUSED) |=> !o_in_ready)
        else $error("accepted item did not start work");

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.found) |-> (o_out_item.event_out == '0))
        else $error("not-found result carries an event id");

endmodule

>>> tb/timed_event_range_query_core_tb.sv
module timed_event_range_query_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import terq_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 300;
    localparam logic signed [TIME_BITS-1:0] T_MIN   = 32'sh8000_0000;
    localparam logic signed [TIME_BITS-1:0] T_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [TIME_BITS-1:0] ONE_SEC = 32'sh0001_0000;

    // Sorted event table mirror plus the queue of results still owed by the block.
    class event_table_sb;
        t_entry    rows[$];
        t_out_item due_results[$];
        int        errors;

        function t_out_item make_result(logic found, logic [EVENT_ID_BITS-1:0] ev,
                                        logic status, logic last);
            t_out_item r;
            r.found     = found;
            r.event_out = ev;
            r.status    = status;
            r.last      = last;
            return r;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void note_item(t_in_item it);
            logic signed [TIME_BITS-1:0] t0, t1, tm;
            t_entry    e;
            t_out_item held;
            bit        have_hit, fwd, hit;
            int        pos, idx;
            t0 = it.time_req;
            t1 = it.range_end;
            have_hit = 1'b0;
            case (it.kind)
                KIND_CLEAR: begin
                    rows.delete();
                    due_results.push_back(make_result(1'b0, '0, STATUS_OK, 1'b1));
                end
                KIND_ADD: begin
                    if (rows.size() >= TABLE_DEPTH) begin
                        due_results.push_back(make_result(1'b0, '0, STATUS_FULL, 1'b1));
                    end else begin
                        // new entry lands after all entries of equal time
                        pos = 0;
                        while (pos < rows.size()) begin
                            tm = rows[pos].tm;
                            if (tm > t0) break;
                            pos++;
                        end
                        e.tm = t0;
                        e.ev = it.event_id;
                        rows.insert(pos, e);
                        due_results.push_back(make_result(1'b0, '0, STATUS_OK, 1'b1));
                    end
                end
                KIND_SAMPLE: begin
                    fwd = (t0 <= t1);
                    for (int k = 0; k < rows.size(); k++) begin
                        idx = fwd ? k : rows.size() - 1 - k;
                        tm  = rows[idx].tm;
                        hit = fwd ? (tm >= t0 && tm < t1) : (tm <= t0 && tm > t1);
                        if (hit) begin
                            if (have_hit) due_results.push_back(held);
                            held = make_result(1'b1, rows[idx].ev, STATUS_OK, 1'b0);
                            have_hit = 1'b1;
                        end
                    end
                    if (have_hit) begin
                        held.last = 1'b1;
                        due_results.push_back(held);
                    end else begin
                        due_results.push_back(make_result(1'b0, '0, STATUS_OK, 1'b1));
                    end
                end
                default: ;  // unused kind: dropped silently
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (due_results.size() == 0) begin
                errors++;
                if (errors < 40)
                    $display("%0t: unexpected result found=%0d event=%0h status=%0d last=%0d",
                             $time, got.found, got.event_out, got.status, got.last);
                return;
            end
            want = due_results.pop_front();
            if (got !== want) begin
                errors++;
                if (errors < 40) begin
                    if (got.found !== want.found)
                        $display("%0t: found expected %0d got %0d",
                                 $time, want.found, got.found);
                    if (got.event_out !== want.event_out)
                        $display("%0t: event_out expected %0h got %0h",
                                 $time, want.event_out, got.event_out);
                    if (got.status !== want.status)
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, got.status);
                    if (got.last !== want.last)
                        $display("%0t: last expected %0d got %0d",
                                 $time, want.last, got.last);
                end
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    int        snd_idle = 0;
    int        rcv_stall = 0;
    logic      hold_go = 1'b0;
    logic      hold_active = 1'b0;
    int        cycle_cnt = 0;

    event_table_sb sb = new();

    timed_event_range_query_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timed_event_range_query_core regression: fail");
            $finish;
        end
    end

    // input monitor: model sees every accepted item
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) sb.note_item(in_item);
    end

    // output side: check, then pick next ready
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_item);
        out_ready <= rst_n && !hold_active && ($urandom_range(99) >= rcv_stall);
    end

    // long output hold-off so the block backs up into its input
    initial begin
        while (!hold_go) @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    function automatic t_in_item mk_item(logic [1:0] kind, logic signed [TIME_BITS-1:0] t0,
                                         logic signed [TIME_BITS-1:0] t1,
                                         logic [EVENT_ID_BITS-1:0] ev);
        t_in_item it;
        it.kind      = kind;
        it.time_req  = t0;
        it.range_end = t1;
        it.event_id  = ev;
        return it;
    endfunction

    // mostly whole seconds in a narrow window so ties and hits are common
    function automatic logic signed [TIME_BITS-1:0] rand_time();
        logic signed [TIME_BITS-1:0] v;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) begin
            v = ($urandom_range(15) - 8) * 65536;
            if ($urandom_range(4) == 0) v[15:0] = 16'($urandom);
        end else if (r < 80) begin
            case ($urandom_range(3))
                0:       v = T_MIN;
                1:       v = T_MAX;
                2:       v = '0;
                default: v = '1;
            endcase
        end else begin
            v = $urandom;
        end
        return v;
    endfunction

    task automatic send_item(t_in_item it);
        if ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < snd_idle);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic run_random(int n);
        t_in_item it;
        int       sent, r, clear_pct;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(99);
            clear_pct = (sb.rows.size() >= TABLE_DEPTH) ? 12 : 1;
            it.time_req  = rand_time();
            it.range_end = rand_time();
            it.event_id  = EVENT_ID_BITS'($urandom);
            if (r < clear_pct)          it.kind = KIND_CLEAR;
            else if (r < clear_pct + 3) it.kind = KIND_UNUSED;
            else if (r < 68)            it.kind = KIND_ADD;
            else                        it.kind = KIND_SAMPLE;
            send_item(it);
            if (it.kind != KIND_UNUSED) sent++;
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, both directions, and an ignored kind
        send_item(mk_item(KIND_SAMPLE, '0, ONE_SEC, 8'h00));
        send_item(mk_item(KIND_SAMPLE, ONE_SEC, '0, 8'h00));
        send_item(mk_item(KIND_UNUSED, ONE_SEC, ONE_SEC, 8'h12));
        // extremes and ties
        send_item(mk_item(KIND_ADD, '0, '0, 8'h00));
        send_item(mk_item(KIND_ADD, T_MAX, '0, 8'hFF));
        send_item(mk_item(KIND_ADD, T_MIN, '0, 8'hA5));
        send_item(mk_item(KIND_ADD, '0, T_MAX, 8'h5A));
        send_item(mk_item(KIND_ADD, 32'sh0001_8000, '0, 8'h01));
        send_item(mk_item(KIND_ADD, -32'sd1, '0, 8'h80));
        send_item(mk_item(KIND_SAMPLE, T_MIN, T_MAX, 8'h00));
        send_item(mk_item(KIND_SAMPLE, T_MAX, T_MIN, 8'h00));
        send_item(mk_item(KIND_SAMPLE, '0, '0, 8'h00));
        send_item(mk_item(KIND_SAMPLE, '0, 32'sd1, 8'h00));
        send_item(mk_item(KIND_SAMPLE, '0, -32'sd1, 8'h00));
        send_item(mk_item(KIND_SAMPLE, T_MAX, T_MAX - 1, 8'h00));
        send_item(mk_item(KIND_UNUSED, '1, '1, 8'hFF));
        send_item(mk_item(KIND_SAMPLE, T_MIN, T_MIN + 1, 8'h00));
        send_item(mk_item(KIND_CLEAR, T_MAX, T_MIN, 8'hFF));
        send_item(mk_item(KIND_SAMPLE, T_MIN, T_MAX, 8'h00));
        send_item(mk_item(KIND_ADD, 5 * ONE_SEC, '0, 8'h33));
        send_item(mk_item(KIND_SAMPLE, 5 * ONE_SEC, 4 * ONE_SEC, 8'h00));
        wait_drain();

        hold_go <= 1'b1;
        run_random(120);
        wait_drain();
        snd_idle = 61;
        run_random(120);
        wait_drain();
        snd_idle = 0;
        rcv_stall <= 61;
        run_random(120);
        wait_drain();
        snd_idle = 35;
        rcv_stall <= 35;
        run_random(120);
        wait_drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("timed_event_range_query_core regression: pass");
        else
            $display("timed_event_range_query_core regression: fail");
        $finish;
    end

endmodule
